// ----- src/tlcd_pkg.sv -----
// shared types and constants of the two-way lru cache directory
package tlcd_pkg;

   localparam int ADDR_BITS        = 32;
   // set count is a power of two so set and tag are a plain bit split
   localparam int SET_COUNT        = 64;
   localparam int LINE_OFFSET_BITS = 3;
   localparam int SET_BITS         = $clog2(SET_COUNT);
   localparam int TAG_BITS         = ADDR_BITS - LINE_OFFSET_BITS - SET_BITS;
   localparam int COUNT_BITS       = 32;

   localparam logic CMD_READ  = 1'b0;
   localparam logic CMD_WRITE = 1'b1;

   typedef struct packed {
      logic [ADDR_BITS-1:0] address;
      logic                 command;
   } req_type;

   typedef struct packed {
      logic                  hit;
      logic                  way;
      logic                  write_back;
      logic [COUNT_BITS-1:0] read_count;
      logic [COUNT_BITS-1:0] write_count;
      logic [COUNT_BITS-1:0] hit_count;
      logic [COUNT_BITS-1:0] miss_count;
      logic [COUNT_BITS-1:0] write_back_count;
   } rsp_type;

   typedef struct packed {
      logic                valid;
      logic                dirty;
      logic [TAG_BITS-1:0] tag;
   } way_entry_type;

   // one memory word holds both ways of a set and its most recently used way
   typedef struct packed {
      logic                recent;
      way_entry_type [1:0] ways;
   } set_entry_type;

   localparam int SET_ENTRY_BITS = $bits(set_entry_type);

   typedef struct packed {
      logic hit;
      logic way;
      logic write_back;
   } look_result_type;

endpackage

// ----- src/tlcd_ram.sv -----
// generic single-port-write, single-port-read ram with registered read
module tlcd_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- src/tlcd_lookup.sv -----
// tag compare, victim choice and updated set entry for one transaction
module tlcd_lookup (
   input  tlcd_pkg::set_entry_type      entry,
   input  logic [tlcd_pkg::TAG_BITS-1:0] tag,
   input  logic                          command,
   output tlcd_pkg::set_entry_type      new_entry,
   output tlcd_pkg::look_result_type    result
);

   logic hit0;
   logic hit1;

   always_comb begin
      hit0 = entry.ways[0].valid && (entry.ways[0].tag == tag);
      hit1 = entry.ways[1].valid && (entry.ways[1].tag == tag);

      result            = '0;
      new_entry         = entry;
      if (hit0) begin
         result.hit = 1'b1;
         result.way = 1'b0;
      end else if (hit1) begin
         result.hit = 1'b1;
         result.way = 1'b1;
      end else begin
         // invalid way first, way 0 before way 1, else the lru way
         if (!entry.ways[0].valid) begin
            result.way = 1'b0;
         end else if (!entry.ways[1].valid) begin
            result.way = 1'b1;
         end else begin
            result.way = !entry.recent;
         end
         result.write_back = entry.ways[result.way].valid && entry.ways[result.way].dirty;
         new_entry.ways[result.way].valid = 1'b1;
         new_entry.ways[result.way].dirty = 1'b0;
         new_entry.ways[result.way].tag   = tag;
      end
      new_entry.recent = result.way;
      if (command == tlcd_pkg::CMD_WRITE) begin
         new_entry.ways[result.way].dirty = 1'b1;
      end
   end

endmodule

// ----- src/two_way_lru_cache_directory.sv -----
// top level of the two-way lru cache directory
//
// channel  dir  signals
// req      in   req_valid, req_ready, req_payload (address, command)
// rsp      out  rsp_valid, rsp_ready, rsp_payload (hit, way, write_back, counts)
//
// one transaction per cycle sustained while rsp is not stalled; an accepted transaction
// meets its registered directory ram read in the lookup stage; its result is registered
// the set entry is written back as the result is registered; a forwarding register
// holds the last written set so a back-to-back access to it sees fresh data
// reset clears per-set valid flags in flops, so there is no clearing pass; counters zero
// a result held on rsp stalls the lookup stage, which then drops req_ready
module two_way_lru_cache_directory (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  tlcd_pkg::req_type req_payload,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output tlcd_pkg::rsp_type rsp_payload
);

   logic [tlcd_pkg::SET_BITS-1:0] req_set;
   logic [tlcd_pkg::TAG_BITS-1:0] req_tag;
   logic                          accept;
   logic                          out_free;
   logic                          advance;
   logic                          fwd_match;

   // lookup stage
   logic                          lk_valid_ff, lk_valid_in;
   logic [tlcd_pkg::SET_BITS-1:0] lk_set_ff, lk_set_in;
   logic [tlcd_pkg::TAG_BITS-1:0] lk_tag_ff, lk_tag_in;
   logic                          lk_command_ff, lk_command_in;

   // last written set entry
   logic                          fwd_valid_ff, fwd_valid_in;
   logic [tlcd_pkg::SET_BITS-1:0] fwd_set_ff, fwd_set_in;
   tlcd_pkg::set_entry_type       fwd_data_ff, fwd_data_in;

   logic [tlcd_pkg::SET_COUNT-1:0] set_init_ff, set_init_in;

   logic [tlcd_pkg::COUNT_BITS-1:0] read_cnt_ff, read_cnt_in;
   logic [tlcd_pkg::COUNT_BITS-1:0] write_cnt_ff, write_cnt_in;
   logic [tlcd_pkg::COUNT_BITS-1:0] hit_cnt_ff, hit_cnt_in;
   logic [tlcd_pkg::COUNT_BITS-1:0] miss_cnt_ff, miss_cnt_in;
   logic [tlcd_pkg::COUNT_BITS-1:0] wb_cnt_ff, wb_cnt_in;

   logic              rsp_valid_ff, rsp_valid_in;
   tlcd_pkg::rsp_type rsp_data_ff, rsp_data_in;

   logic [tlcd_pkg::SET_ENTRY_BITS-1:0] ram_rd_data;
   tlcd_pkg::set_entry_type             cur_entry;
   tlcd_pkg::set_entry_type             new_entry;
   tlcd_pkg::look_result_type           look;

   always_comb begin
      req_set   = req_payload.address[tlcd_pkg::LINE_OFFSET_BITS +: tlcd_pkg::SET_BITS];
      req_tag   = req_payload.address[tlcd_pkg::ADDR_BITS-1 -: tlcd_pkg::TAG_BITS];
      out_free  = !rsp_valid_ff || rsp_ready;
      advance   = lk_valid_ff && out_free;
      req_ready = !lk_valid_ff || out_free;
      accept    = req_valid && req_ready;
      fwd_match = fwd_valid_ff && (fwd_set_ff == lk_set_ff);
      if (fwd_match) begin
         cur_entry = fwd_data_ff;
      end else if (set_init_ff[lk_set_ff]) begin
         cur_entry = tlcd_pkg::set_entry_type'(ram_rd_data);
      end else begin
         cur_entry = '0;
      end
   end

   tlcd_ram #(
      .WIDTH(tlcd_pkg::SET_ENTRY_BITS),
      .DEPTH(tlcd_pkg::SET_COUNT)
   ) u_dir_ram (
      .clock  (clock),
      .wr_en  (advance),
      .wr_addr(lk_set_ff),
      .wr_data(new_entry),
      .rd_en  (accept),
      .rd_addr(req_set),
      .rd_data(ram_rd_data)
   );

   tlcd_lookup u_lookup (
      .entry    (cur_entry),
      .tag      (lk_tag_ff),
      .command  (lk_command_ff),
      .new_entry(new_entry),
      .result   (look)
   );

   always_comb begin
      lk_valid_in   = accept ? 1'b1 : (advance ? 1'b0 : lk_valid_ff);
      lk_set_in     = accept ? req_set : lk_set_ff;
      lk_tag_in     = accept ? req_tag : lk_tag_ff;
      lk_command_in = accept ? req_payload.command : lk_command_ff;

      fwd_valid_in = fwd_valid_ff || advance;
      fwd_set_in   = advance ? lk_set_ff : fwd_set_ff;
      fwd_data_in  = advance ? new_entry : fwd_data_ff;

      set_init_in = set_init_ff;
      read_cnt_in  = read_cnt_ff;
      write_cnt_in = write_cnt_ff;
      hit_cnt_in   = hit_cnt_ff;
      miss_cnt_in  = miss_cnt_ff;
      wb_cnt_in    = wb_cnt_ff;
      if (advance) begin
         set_init_in[lk_set_ff] = 1'b1;
         if (lk_command_ff == tlcd_pkg::CMD_WRITE) begin
            write_cnt_in = write_cnt_ff + 1'b1;
         end else begin
            read_cnt_in = read_cnt_ff + 1'b1;
         end
         if (look.hit) begin
            hit_cnt_in = hit_cnt_ff + 1'b1;
         end else begin
            miss_cnt_in = miss_cnt_ff + 1'b1;
         end
         if (look.write_back) begin
            wb_cnt_in = wb_cnt_ff + 1'b1;
         end
      end

      rsp_valid_in = advance ? 1'b1 : (rsp_ready ? 1'b0 : rsp_valid_ff);
      rsp_data_in  = rsp_data_ff;
      if (advance) begin
         rsp_data_in.hit              = look.hit;
         rsp_data_in.way              = look.way;
         rsp_data_in.write_back       = look.write_back;
         rsp_data_in.read_count       = read_cnt_in;
         rsp_data_in.write_count      = write_cnt_in;
         rsp_data_in.hit_count        = hit_cnt_in;
         rsp_data_in.miss_count       = miss_cnt_in;
         rsp_data_in.write_back_count = wb_cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         lk_valid_ff  <= 1'b0;
         fwd_valid_ff <= 1'b0;
         set_init_ff  <= '0;
         read_cnt_ff  <= '0;
         write_cnt_ff <= '0;
         hit_cnt_ff   <= '0;
         miss_cnt_ff  <= '0;
         wb_cnt_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         lk_valid_ff  <= lk_valid_in;
         fwd_valid_ff <= fwd_valid_in;
         set_init_ff  <= set_init_in;
         read_cnt_ff  <= read_cnt_in;
         write_cnt_ff <= write_cnt_in;
         hit_cnt_ff   <= hit_cnt_in;
         miss_cnt_ff  <= miss_cnt_in;
         wb_cnt_ff    <= wb_cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      lk_set_ff     <= lk_set_in;
      lk_tag_ff     <= lk_tag_in;
      lk_command_ff <= lk_command_in;
      fwd_set_ff    <= fwd_set_in;
      fwd_data_ff   <= fwd_data_in;
      rsp_data_ff   <= rsp_data_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_data_ff;

   // a dirty victim is only ever reported on a miss
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> !(rsp_data_ff.hit && rsp_data_ff.write_back))
      else $error("write-back reported on a hit");

   // every transaction counts once as read or write and once as hit or miss
   assert property (@(posedge clock) disable iff (reset)
      (hit_cnt_ff + miss_cnt_ff) == (read_cnt_ff + write_cnt_ff))
      else $error("hit and miss counts disagree with transaction counts");

   // a stalled lookup keeps its set and tag
   assert property (@(posedge clock) disable iff (reset)
      (lk_valid_ff && !out_free) |=>
         (lk_valid_ff && $stable(lk_set_ff) && $stable(lk_tag_ff)))
      else $error("lookup stage lost its transaction during a stall");

endmodule
